/* design/pcxrle_pkg.sv */
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types and constants of the 8-bit palette RLE decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcxrle_pkg;

    localparam int unsigned CFG_W             = 13;
    localparam int unsigned CFG_MAX           = (1 << CFG_W) - 1;
    localparam int unsigned MAX_DIM_DEF       = 4096;
    localparam int unsigned PALETTE_DEPTH_DEF = 256;
    localparam int unsigned COLOR_W           = 24;
    localparam int unsigned COORD_W           = 12;
    localparam int unsigned RUN_W             = 6;

    localparam logic [7:0] COUNT_MARK = 8'hC0;

    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam logic [1:0] REG_BYTES_PER_LINE = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] bytes_per_line;
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic [CFG_W-1:0] column;
        logic [CFG_W-1:0] row;
        logic             padding;
        logic             image_end;
    } pos_t;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] lim);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > lim) begin
            r = lim;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/pcxrle_apb_regs.sv */
// ----------------------------------------------------------------------------
// pcxrle_apb_regs
// APB register file holding line length, visible width and image height.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxrle_apb_regs
    import pcxrle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                REG_BYTES_PER_LINE: cfg_next.bytes_per_line = pwdata[CFG_W-1:0];
                REG_IMAGE_WIDTH:    cfg_next.image_width    = pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT:   cfg_next.image_height   = pwdata[CFG_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BYTES_PER_LINE: prdata = 32'(cfg_reg.bytes_per_line);
            REG_IMAGE_WIDTH:    prdata = 32'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT:   prdata = 32'(cfg_reg.image_height);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bytes_per_line <= CFG_W'(1);
            cfg_reg.image_width    <= CFG_W'(1);
            cfg_reg.image_height   <= CFG_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* design/pcxrle_palette_ram.sv */
// ----------------------------------------------------------------------------
// pcxrle_palette_ram
// Color table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxrle_palette_ram
    import pcxrle_pkg::*;
#(
    parameter int unsigned DEPTH = PALETTE_DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [COLOR_W-1:0] wdata,
    input  wire logic               re,
    input  wire logic [AW-1:0]      raddr,
    output logic      [COLOR_W-1:0] rdata
);

    logic [COLOR_W-1:0] mem [DEPTH];
    logic [COLOR_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/pcxrle_pos_counter.sv */
// ----------------------------------------------------------------------------
// pcxrle_pos_counter
// Column and row tracker with padding and end-of-image flags.
// ----------------------------------------------------------------------------
`default_nettype none

module pcxrle_pos_counter
    import pcxrle_pkg::*;
#(
    parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire logic advance,
    output pos_t      pos
);

    localparam int unsigned DIM_LIM = (MAX_DIM > CFG_MAX) ? CFG_MAX : MAX_DIM;
    localparam logic [CFG_W-1:0] DIM_LIM_V = CFG_W'(DIM_LIM);

    logic [CFG_W-1:0] col_reg, col_next;
    logic [CFG_W-1:0] row_reg, row_next;
    logic [CFG_W-1:0] bpl_c, h_c;
    logic             col_wrap, row_wrap;

    assign bpl_c    = clamp_dim(cfg.bytes_per_line, DIM_LIM_V);
    assign h_c      = clamp_dim(cfg.image_height, DIM_LIM_V);
    assign col_wrap = ({1'b0, col_reg} + (CFG_W+1)'(1)) >= {1'b0, bpl_c};
    assign row_wrap = ({1'b0, row_reg} + (CFG_W+1)'(1)) >= {1'b0, h_c};

    assign pos.column    = col_reg;
    assign pos.row       = row_reg;
    assign pos.padding   = col_reg >= cfg.image_width;
    assign pos.image_end = (col_reg == bpl_c - CFG_W'(1)) && (row_reg == h_c - CFG_W'(1));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + CFG_W'(1);
            end else begin
                col_next = col_reg + CFG_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

/* design/pcx_8bit_palette_rle_decoder.sv */
// ----------------------------------------------------------------------------
// pcx_8bit_palette_rle_decoder
// 8-bit PCX run-length decoder with a 256-entry RGB palette.
// ----------------------------------------------------------------------------
// a pixel's byte or run value is registered in the run state, then its palette read and position are registered on m_
// throughput: one beat per cycle for literals, prefixes and palette writes while m_tready does not stall a pixel
// a run of n pixels holds s_tready low until its last pixel issues, one palette read each,
// and longer whenever m_tready stalls a pixel
// reset clears run and position state; registers reset to 1
// palette contents are undefined after reset until written
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_8bit_palette_rle_decoder
    import pcxrle_pkg::*;
#(
    parameter int unsigned MAX_DIM       = MAX_DIM_DEF,
    parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // data_byte, palette_index, palette_red,
                                       // palette_green, palette_blue
    input  wire logic [0:0]  s_tuser,  // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,  // red, green, blue, column, row
    output logic      [1:0]  m_tuser,  // padding, image_end
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int unsigned AW = $clog2(PALETTE_DEPTH);

    cfg_t cfg;
    pos_t pos;

    logic             s_acc, pal_we, data_acc, issue;
    logic [7:0]       in_byte;
    logic [COLOR_W-1:0] rgb;

    logic             pending_reg, pending_next;
    logic [RUN_W-1:0] len_reg, len_next;
    logic [RUN_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       value_reg, value_next;

    logic             m_valid_reg, m_valid_next;
    logic [COORD_W-1:0] col_reg, row_reg;
    logic             pad_reg, end_reg, last_reg;

    pcxrle_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcxrle_pos_counter #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (issue),
        .pos     (pos)
    );

    pcxrle_palette_ram #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_pal (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (AW'(s_tdata[15:8])),
        .wdata ({s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]}),
        .re    (issue),
        .raddr (AW'(value_reg)),
        .rdata (rgb)
    );

    assign in_byte  = s_tdata[7:0];
    assign issue    = (cnt_reg != '0) && (!m_valid_reg || m_tready);
    assign s_tready = (cnt_reg == '0) || ((cnt_reg == RUN_W'(1)) && issue);
    assign s_acc    = s_tvalid && s_tready;
    assign pal_we   = s_acc && (s_tuser[0] == OP_PALETTE);
    assign data_acc = s_acc && (s_tuser[0] == OP_DATA);

    always_comb begin
        pending_next = pending_reg;
        len_next     = len_reg;
        value_next   = value_reg;
        cnt_next     = issue ? cnt_reg - RUN_W'(1) : cnt_reg;
        if (data_acc) begin
            if (pending_reg) begin
                pending_next = 1'b0;
                len_next     = '0;
                cnt_next     = len_reg;
                value_next   = in_byte;
            end else if (in_byte >= COUNT_MARK) begin
                pending_next = 1'b1;
                len_next     = in_byte[RUN_W-1:0];
            end else begin
                cnt_next     = RUN_W'(1);
                value_next   = in_byte;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (issue) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            len_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        if (issue) begin
            col_reg  <= pos.column[COORD_W-1:0];
            row_reg  <= pos.row[COORD_W-1:0];
            pad_reg  <= pos.padding;
            end_reg  <= pos.image_end;
            last_reg <= (cnt_reg == RUN_W'(1));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {row_reg, col_reg, rgb[7:0], rgb[15:8], rgb[23:16]};
    assign m_tuser  = {end_reg, pad_reg};
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_last_of_run : assert property (@(posedge aclk) disable iff (!aresetn)
        issue && (cnt_reg == RUN_W'(1)) |=> m_tvalid && m_tlast)
        else $error("final pixel of a run not marked last");

    a_prefix_pends : assert property (@(posedge aclk) disable iff (!aresetn)
        data_acc && !pending_reg && (in_byte >= COUNT_MARK) |=> pending_reg)
        else $error("count prefix did not arm a run");

    a_busy_blocks_input : assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg > RUN_W'(1)) |-> !s_tready)
        else $error("input taken during run expansion");
`endif

endmodule

`default_nettype wire

/* tb/tb_pcx_8bit_palette_rle_decoder.sv */
// ----------------------------------------------------------------------------
// tb_pcx_8bit_palette_rle_decoder
// Self-checking bench for the 8-bit palette RLE decoder. It loads color table
// entries and sends literal bytes, count prefixes and run values over the
// input stream. An internal decoder model predicts every pixel beat: color,
// column, row, padding, run end and image end. The bench sweeps the line,
// width and height registers across minimum, maximum and out-of-range values.
// Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pcx_8bit_palette_rle_decoder;
    import pcxrle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        padding;
        logic        run_last;
        logic        image_end;
    } pixel_t;

    class pixel_tracker;
        logic [23:0] color_table [256];
        logic [12:0] line_bytes = 13'd1;
        logic [12:0] visible_width = 13'd1;
        logic [12:0] line_count = 13'd1;
        bit          run_pending = 1'b0;
        logic [5:0]  run_len = '0;
        int unsigned pos = 0;
        int unsigned line = 0;
        pixel_t      pixels_due[$];
        int          mismatches = 0;

        function int unsigned clamped(logic [12:0] v);
            if (v == 13'd0) return 1;
            if (v > 13'd4096) return 4096;
            return v;
        endfunction

        function void set_reg(logic [1:0] idx, logic [12:0] v);
            case (idx)
                REG_BYTES_PER_LINE: line_bytes = v;
                REG_IMAGE_WIDTH:    visible_width = v;
                REG_IMAGE_HEIGHT:   line_count = v;
                default: ;
            endcase
        endfunction

        function void emit(logic [7:0] value, bit last);
            int unsigned bpl;
            int unsigned h;
            pixel_t p;
            bpl = clamped(line_bytes);
            h = clamped(line_count);
            {p.red, p.green, p.blue} = color_table[value];
            p.column = pos[11:0];
            p.row = line[11:0];
            p.padding = (pos >= visible_width);
            p.run_last = last;
            p.image_end = (pos == bpl - 1) && (line == h - 1);
            pixels_due.push_back(p);
            // positions left beyond shrunken bounds wrap here
            if (pos + 1 >= bpl) begin
                pos = 0;
                line = (line + 1 >= h) ? 0 : line + 1;
            end else begin
                pos = pos + 1;
            end
        endfunction

        function void take_beat(logic op, logic [7:0] data, logic [7:0] idx,
                                logic [23:0] rgb);
            int unsigned n;
            if (op == OP_PALETTE) begin
                color_table[idx] = rgb;
                return;
            end
            if (run_pending) begin
                n = run_len;
                run_pending = 1'b0;
                run_len = '0;
                for (int unsigned i = 0; i < n; i++) emit(data, i + 1 == n);
                return;
            end
            if (data >= COUNT_MARK) begin
                run_pending = 1'b1;
                run_len = 6'(data - COUNT_MARK);
                return;
            end
            emit(data, 1'b1);
        endfunction

        function void compare(string name, int unsigned exp, int unsigned got);
            if (exp != got) begin
                $error("%s mismatch: expected %0h, got %0h", name, exp, got);
                mismatches++;
            end
        endfunction

        function void check_pixel(logic [47:0] tdata, logic [1:0] tuser, logic tlast);
            pixel_t p;
            if (pixels_due.size() == 0) begin
                $error("pixel beat with nothing expected: tdata %0h", tdata);
                mismatches++;
                return;
            end
            p = pixels_due.pop_front();
            compare("red", p.red, tdata[7:0]);
            compare("green", p.green, tdata[15:8]);
            compare("blue", p.blue, tdata[23:16]);
            compare("column", p.column, tdata[35:24]);
            compare("row", p.row, tdata[47:36]);
            compare("padding", p.padding, tuser[0]);
            compare("image_end", p.image_end, tuser[1]);
            compare("run_last", p.run_last, tlast);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // data_byte, palette_index, red, green, blue
    logic [0:0]  s_tuser = '0;   // operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // red, green, blue, column, row
    logic [1:0]  m_tuser;        // padding, image_end
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pixel_tracker sb = new();
    bit           entry_loaded [256];
    logic [7:0]   loaded_any[$];
    logic [7:0]   loaded_literal[$];
    int           burst_left = 0;
    int unsigned  ready_cyc = 0;
    int           stall_left = 0;

    pcx_8bit_palette_rle_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver: free-running, random, bursty stalls, then alternating
    always @(posedge aclk) begin
        ready_cyc <= ready_cyc + 1;
        case ((ready_cyc / 700) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2: begin
                if (stall_left > 0) begin
                    stall_left <= stall_left - 1;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 11) == 0) begin
                    stall_left <= $urandom_range(1, 8);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
            default: m_tready <= ready_cyc[0];
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tuser, m_tlast);
    end

    task automatic send_beat(logic op, logic [7:0] data, logic [7:0] idx, logic [23:0] rgb);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {rgb[7:0], rgb[15:8], rgb[23:16], idx, data};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        sb.take_beat(op, data, idx, rgb);
        if (op == OP_PALETTE && !entry_loaded[idx]) begin
            entry_loaded[idx] = 1'b1;
            loaded_any.push_back(idx);
            if (idx < COUNT_MARK) loaded_literal.push_back(idx);
        end
    endtask

    task automatic send_data(logic [7:0] data);
        send_beat(OP_DATA, data, 8'($urandom), 24'($urandom));
    endtask

    task automatic send_palette(logic [7:0] idx, logic [23:0] rgb);
        send_beat(OP_PALETTE, 8'($urandom), idx, rgb);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic configure(logic [12:0] bpl, logic [12:0] width, logic [12:0] height);
        write_reg(REG_BYTES_PER_LINE, bpl);
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
    endtask

    task automatic random_phase(int count, bit pause_midway);
        logic [7:0] value;
        int         pick;
        for (int k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2) wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_palette(8'($urandom), 24'($urandom));
            end else if (sb.run_pending) begin
                // an empty run never reads the table
                if (sb.run_len == 0) value = 8'($urandom);
                else value = loaded_any[$urandom_range(0, loaded_any.size() - 1)];
                send_data(value);
            end else if (pick < 40) begin
                if ($urandom_range(0, 9) == 0) value = COUNT_MARK + 8'($urandom_range(0, 63));
                else value = COUNT_MARK + 8'($urandom_range(0, 6));
                send_data(value);
            end else begin
                send_data(loaded_literal[$urandom_range(0, loaded_literal.size() - 1)]);
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        configure(13'd5, 13'd3, 13'd3);

        send_palette(8'h00, 24'h000000);
        send_palette(8'hFF, 24'hFFFFFF);
        send_palette(8'hC0, 24'h123456);
        send_palette(8'hBF, 24'hA55AC3);
        send_palette(8'h55, 24'h0FF03C);
        send_palette(8'hAA, 24'h80017E);
        send_data(8'h00);
        send_data(8'hBF);
        send_data(8'hC3);
        send_data(8'hFF);
        // empty run, value byte consumed without a pixel
        send_data(COUNT_MARK);
        send_data(8'h55);
        send_data(COUNT_MARK);
        send_data(8'hD7);
        // longest run with a table write between prefix and value
        send_data(8'hFF);
        send_palette(8'h3F, 24'h112233);
        send_data(8'hC0);
        send_data(8'h55);
        send_data(8'hC1);
        send_data(8'hAA);
        wait_drained();

        configure(13'd1, 13'd1, 13'd1);
        random_phase(52, 1'b1);
        configure(13'd4096, 13'd4096, 13'd4096);
        random_phase(52, 1'b0);
        configure(13'd0, 13'd0, 13'd0);
        random_phase(52, 1'b0);
        configure(13'd8191, 13'd8191, 13'd8191);
        random_phase(52, 1'b0);
        configure(13'd7, 13'd4, 13'd2);
        random_phase(52, 1'b0);
        configure(13'd16, 13'd16, 13'd1);
        random_phase(52, 1'b0);
        configure(13'd3, 13'd1, 13'd5);
        random_phase(52, 1'b1);
        configure(13'($urandom_range(1, 40)), 13'($urandom_range(0, 45)),
                  13'($urandom_range(1, 6)));
        random_phase(52, 1'b0);

        s_tvalid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
